@@ sv/alm_pkg.sv @@
// Shared constants, types and helpers for the audio level meter with peak hold.
package alm_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int CNT_W        = 4;
  localparam int SAMPLE_W     = 16;
  localparam int SUM_W        = 16;
  localparam int RUN_W        = 8;
  localparam int MAG_W        = 9;
  localparam int FRAME_W      = 8;
  localparam int LEVEL_W      = 7;
  localparam int AGE_W        = 6;
  localparam int MARK_W       = 2;

  // Divider: numerator sum*40, denominator frames*42, nine quotient bits.
  localparam int NUM_W        = 22;
  localparam int DEN_W        = 14;
  localparam int Q_W          = 9;
  localparam int STEP_W       = 4;
  localparam int DEN_SHIFT    = Q_W - 1;

  localparam logic [FRAME_W-1:0] MAX_FRAMES = FRAME_W'(200);
  localparam logic [MAG_W-1:0]   CLIP_LEVEL = MAG_W'(128);
  localparam logic [RUN_W-1:0]   SHORT_RUN  = RUN_W'(3);
  localparam logic [RUN_W-1:0]   LONG_RUN   = RUN_W'(10);
  localparam logic [RUN_W-1:0]   RUN_MAX    = {RUN_W{1'b1}};
  localparam logic [LEVEL_W-1:0] SHORT_CODE = LEVEL_W'(123);
  localparam logic [LEVEL_W-1:0] LONG_CODE  = LEVEL_W'(127);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = LEVEL_W'(127);
  localparam logic [AGE_W-1:0]   AGE_LIMIT  = AGE_W'(50);
  localparam logic [NUM_W-1:0]   SUM_SCALE  = NUM_W'(40);
  localparam logic [DEN_W-1:0]   DEN_SCALE  = DEN_W'(42);
  localparam logic [CNT_W-1:0]   CNT_RESET  = CNT_W'(2);
  localparam logic [STEP_W-1:0]  DIV_STEPS  = STEP_W'(DEN_SHIFT);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_DIV  = 5'b00100,
    S_PEAK = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  // Clamp the programmed channel count to 1..MAX_CHANNELS.
  function automatic logic [CNT_W-1:0] eff_channels(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (c > CNT_W'(MAX_CHANNELS)) begin
      r = CNT_W'(MAX_CHANNELS);
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

@@ sv/audio_level_meter_peak_hold_unit.sv @@
// Audio level meter with per-channel clip detection, bit-serial level divider and peak hold.
// Samples arrive interleaved, channel 0 first, one per cycle while in_stall is low; the
// magnitude of each (sample/128 toward zero) is added to the channel's sum and its clip
// run is tracked. The sample flagged block_end stops input; the block then reports every
// active channel in turn. Each report passes a load state, the restoring divider that
// forms sum*40/(frames*42) one quotient bit per cycle, a peak-hold state and the output
// register, where it waits out any output stall. Input is accepted again once the final
// channel's result is taken.
module audio_level_meter_peak_hold_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [alm_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic                                in_block_end,
  input  logic                                cfg_we,
  input  logic        [alm_pkg::CNT_W-1:0]    cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [alm_pkg::CH_W-1:0]     out_channel_index,
  output logic        [alm_pkg::LEVEL_W-1:0]  out_level,
  output logic        [alm_pkg::LEVEL_W-1:0]  out_peak,
  output logic                                out_last_channel
);

  localparam int NCH = alm_pkg::MAX_CHANNELS;

  alm_pkg::state_t                state_r;
  logic [alm_pkg::CNT_W-1:0]      count_r;
  logic [alm_pkg::SUM_W-1:0]      sum_r   [NCH];
  logic [alm_pkg::RUN_W-1:0]      run_r   [NCH];
  logic [alm_pkg::MARK_W-1:0]     marks_r [NCH];
  logic [alm_pkg::LEVEL_W-1:0]    peak_r  [NCH];
  logic [alm_pkg::AGE_W-1:0]      age_r   [NCH];
  logic [alm_pkg::FRAME_W-1:0]    frame_r;
  logic [alm_pkg::CH_W-1:0]       pos_r;
  logic [alm_pkg::FRAME_W-1:0]    frames_r;
  logic [alm_pkg::CH_W-1:0]       k_r;
  logic [alm_pkg::STEP_W-1:0]     step_r;
  logic                           out_valid_r;

  // Divider datapath and output payload
  logic [alm_pkg::NUM_W-1:0]      rem_r;
  logic [alm_pkg::NUM_W-1:0]      den_sh_r;
  logic [alm_pkg::Q_W-1:0]        q_r;
  logic [alm_pkg::MARK_W-1:0]     marks_k_r;
  logic [alm_pkg::CH_W-1:0]       out_ch_r;
  logic [alm_pkg::LEVEL_W-1:0]    out_level_r;
  logic [alm_pkg::LEVEL_W-1:0]    out_peak_r;
  logic                           out_last_r;

  logic [alm_pkg::CNT_W-1:0]      n;
  logic [alm_pkg::CH_W-1:0]       ch;
  logic [alm_pkg::CH_W:0]         ch_inc;
  logic [alm_pkg::SAMPLE_W:0]     abs_val;
  logic [alm_pkg::MAG_W-1:0]      mag;
  logic                           in_fire;
  logic                           taking;
  logic [alm_pkg::SUM_W-1:0]      sum_nxt;
  logic [alm_pkg::RUN_W-1:0]      run_nxt;
  logic [alm_pkg::MARK_W-1:0]     marks_nxt;
  logic                           div_ge;
  logic [alm_pkg::LEVEL_W-1:0]    level_nxt;
  logic [alm_pkg::AGE_W-1:0]      age_inc;
  logic                           peak_take;
  logic                           last_k;

  assign n        = alm_pkg::eff_channels(count_r);
  assign ch       = ({1'b0, pos_r} >= n) ? '0 : pos_r;
  assign ch_inc   = {1'b0, ch} + (alm_pkg::CH_W+1)'(1);
  assign in_stall = (state_r != alm_pkg::S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign taking   = (frame_r < alm_pkg::MAX_FRAMES);

  // Magnitude of the sample, then drop seven bits; -32768 lands on 256
  always_comb begin
    if (in_sample_value[alm_pkg::SAMPLE_W-1]) begin
      abs_val = (alm_pkg::SAMPLE_W+1)'(1 << alm_pkg::SAMPLE_W)
              - {1'b0, in_sample_value};
    end else begin
      abs_val = {1'b0, in_sample_value};
    end
  end
  assign mag = abs_val[alm_pkg::SAMPLE_W-1:alm_pkg::SAMPLE_W-alm_pkg::MAG_W];

  always_comb begin
    sum_nxt = sum_r[ch] + alm_pkg::SUM_W'(mag);
    if (mag >= alm_pkg::CLIP_LEVEL) begin
      run_nxt = (run_r[ch] == alm_pkg::RUN_MAX) ? run_r[ch]
              : run_r[ch] + alm_pkg::RUN_W'(1);
    end else begin
      run_nxt = '0;
    end
    marks_nxt = marks_r[ch] | {run_nxt > alm_pkg::LONG_RUN, run_nxt > alm_pkg::SHORT_RUN};
  end

  assign div_ge = (rem_r >= den_sh_r);

  always_comb begin
    if (marks_k_r[1]) begin
      level_nxt = alm_pkg::LONG_CODE;
    end else if (marks_k_r[0]) begin
      level_nxt = alm_pkg::SHORT_CODE;
    end else if (q_r[alm_pkg::Q_W-1] || q_r[alm_pkg::Q_W-2]) begin
      level_nxt = alm_pkg::LEVEL_MAX;
    end else begin
      level_nxt = q_r[alm_pkg::LEVEL_W-1:0];
    end
  end

  assign age_inc   = age_r[k_r] + alm_pkg::AGE_W'(1);
  assign peak_take = (peak_r[k_r] < level_nxt) || (age_inc > alm_pkg::AGE_LIMIT);
  assign last_k    = ({1'b0, k_r} + alm_pkg::CNT_W'(1)) == n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alm_pkg::S_IDLE;
      count_r     <= alm_pkg::CNT_RESET;
      frame_r     <= '0;
      pos_r       <= '0;
      frames_r    <= '0;
      k_r         <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NCH; i++) begin
        sum_r[i]   <= '0;
        run_r[i]   <= '0;
        marks_r[i] <= '0;
        peak_r[i]  <= '0;
        age_r[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        count_r <= cfg_wdata;
        // Drop the peak hold when the active channel set changes
        if (alm_pkg::eff_channels(cfg_wdata) != n) begin
          for (int i = 0; i < NCH; i++) begin
            peak_r[i] <= '0;
            age_r[i]  <= '0;
          end
        end
      end
      case (state_r)
        alm_pkg::S_IDLE: begin
          if (in_fire) begin
            if (taking) begin
              sum_r[ch]   <= sum_nxt;
              run_r[ch]   <= run_nxt;
              marks_r[ch] <= marks_nxt;
            end
            if (in_block_end) begin
              frames_r <= taking ? frame_r + alm_pkg::FRAME_W'(1) : alm_pkg::MAX_FRAMES;
              k_r      <= '0;
              state_r  <= alm_pkg::S_LOAD;
            end else if (ch_inc >= n) begin
              pos_r <= '0;
              if (taking) begin
                frame_r <= frame_r + alm_pkg::FRAME_W'(1);
              end
            end else begin
              pos_r <= ch_inc[alm_pkg::CH_W-1:0];
            end
          end
        end
        alm_pkg::S_LOAD: begin
          step_r  <= alm_pkg::DIV_STEPS;
          state_r <= alm_pkg::S_DIV;
        end
        alm_pkg::S_DIV: begin
          if (step_r == '0) begin
            state_r <= alm_pkg::S_PEAK;
          end else begin
            step_r <= step_r - alm_pkg::STEP_W'(1);
          end
        end
        alm_pkg::S_PEAK: begin
          if (peak_take) begin
            peak_r[k_r] <= level_nxt;
            age_r[k_r]  <= '0;
          end else begin
            age_r[k_r]  <= age_inc;
          end
          out_valid_r <= 1'b1;
          state_r     <= alm_pkg::S_OUT;
        end
        alm_pkg::S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              // Close the block: restart accumulation
              for (int i = 0; i < NCH; i++) begin
                sum_r[i]   <= '0;
                run_r[i]   <= '0;
                marks_r[i] <= '0;
              end
              frame_r <= '0;
              pos_r   <= '0;
              state_r <= alm_pkg::S_IDLE;
            end else begin
              k_r     <= k_r + alm_pkg::CH_W'(1);
              state_r <= alm_pkg::S_LOAD;
            end
          end
        end
        default: begin
          state_r <= alm_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Restoring divider, one quotient bit per cycle, top two bits flag overflow
  always_ff @(posedge clk) begin
    case (state_r)
      alm_pkg::S_LOAD: begin
        rem_r     <= alm_pkg::NUM_W'(sum_r[k_r]) * alm_pkg::SUM_SCALE;
        den_sh_r  <= {alm_pkg::DEN_W'(frames_r) * alm_pkg::DEN_SCALE,
                      {alm_pkg::DEN_SHIFT{1'b0}}};
        q_r       <= '0;
        marks_k_r <= marks_r[k_r];
      end
      alm_pkg::S_DIV: begin
        if (div_ge) begin
          rem_r <= rem_r - den_sh_r;
        end
        q_r      <= {q_r[alm_pkg::Q_W-2:0], div_ge};
        den_sh_r <= den_sh_r >> 1;
      end
      alm_pkg::S_PEAK: begin
        out_ch_r    <= k_r;
        out_level_r <= level_nxt;
        out_peak_r  <= peak_take ? level_nxt : peak_r[k_r];
        out_last_r  <= last_k;
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_channel_index = out_ch_r;
  assign out_level         = out_level_r;
  assign out_peak          = out_peak_r;
  assign out_last_channel  = out_last_r;

`ifndef SYNTHESIS
  a_no_input_during_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  a_peak_covers_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_peak >= out_level))
    else $error("held peak below reported level");

  a_last_is_final_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_channel) |->
      ({1'b0, out_channel_index} + alm_pkg::CNT_W'(1)) == n)
    else $error("last channel flag on wrong channel");

  a_block_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_channel) |=>
      (frame_r == '0) && (pos_r == '0) && !in_stall)
    else $error("block state not cleared after final result");
`endif

endmodule
